### rtl/svo_pkg.sv
// shared types, codes and constants for the synth voice oscillator
// no dependencies; used by svo_ctrl, svo_datapath and the top level

package svo_pkg;

  // default parameter values
  localparam int unsigned SAMPLE_RATE_DEF = 48000;
  localparam int unsigned PHASE_BITS_DEF  = 32;
  localparam int unsigned SINE_DEPTH_DEF  = 256;

  // request function codes
  localparam logic [1:0] FUNC_NOTE_START = 2'd0;
  localparam logic [1:0] FUNC_NOTE_STOP  = 2'd1;
  localparam logic [1:0] FUNC_TICK       = 2'd2;

  // wave shape register codes
  localparam logic [1:0] SHAPE_SINE     = 2'd0;
  localparam logic [1:0] SHAPE_SAW      = 2'd1;
  localparam logic [1:0] SHAPE_SQUARE   = 2'd2;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd3;

  localparam int unsigned NOTE_COUNT = 128;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned ENV_W      = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned RAW_W      = 18;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned SAMPLE_W   = 16;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 31;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // output scaling: round(3p / (635 * 2^16)) done as a shift then a reciprocal divide
  localparam int unsigned P_W         = 40;
  localparam int unsigned T_W         = 24;
  localparam int unsigned Q_W         = 15;
  localparam int unsigned SCALE_SHIFT = 16;
  localparam int unsigned SCALE_DIV   = 635;
  localparam int unsigned RECIP_SHIFT = 34;
  localparam logic [P_W-1:0] SCALE_HALF = P_W'(20807680);
  localparam logic [MUL_B_W-1:0] SCALE_RECIP =
    MUL_B_W'((64'd1 << RECIP_SHIFT) / SCALE_DIV);

  localparam logic [SAMPLE_W-1:0] SAT_POS     = 16'd32767;
  localparam logic [SAMPLE_W-1:0] SAT_NEG_MAG = 16'd32768;
  localparam logic [SAMPLE_W-1:0] SAT_NEG     = 16'h8000;

  // tables used at elaboration
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] SEMITONE_Q30 [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };
  localparam int unsigned TAYLOR_DIV [5] = '{6, 20, 42, 72, 110};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROM,
    ST_MAG,
    ST_LEVEL,
    ST_RECIP,
    ST_OUT
  } svo_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROM,
    OP_MAG,
    OP_LEVEL,
    OP_RECIP,
    OP_OUT
  } svo_op_e;

  typedef struct packed {
    logic    note_start;
    logic    hard_stop;
    logic    tick;
    svo_op_e op;
  } svo_cmd_t;

  typedef struct packed {
    logic sounding;
    logic out_free;
  } svo_status_t;

endpackage

### rtl/svo_ctrl.sv
// sequencer for the voice: decodes requests and steps a tick through the datapath
// depends on svo_pkg

module svo_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          func_i,
  input  logic                tail_off_i,
  output logic                in_stall_o,
  input  svo_pkg::svo_status_t status_i,
  output svo_pkg::svo_cmd_t    cmd_o
);

  svo_pkg::svo_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svo_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o.note_start = 1'b0;
    cmd_o.hard_stop  = 1'b0;
    cmd_o.tick       = 1'b0;
    cmd_o.op         = svo_pkg::OP_NONE;
    in_stall_o       = (state_q != svo_pkg::ST_IDLE);
    case (state_q)
      svo_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            svo_pkg::FUNC_NOTE_START: cmd_o.note_start = 1'b1;
            svo_pkg::FUNC_NOTE_STOP:  cmd_o.hard_stop  = !tail_off_i;
            svo_pkg::FUNC_TICK: begin
              // ticks on a silent voice are dropped
              if (status_i.sounding) begin
                cmd_o.tick = 1'b1;
                state_d    = svo_pkg::ST_ROM;
              end
            end
            default: ;
          endcase
        end
      end
      svo_pkg::ST_ROM: begin
        cmd_o.op = svo_pkg::OP_ROM;
        state_d  = svo_pkg::ST_MAG;
      end
      svo_pkg::ST_MAG: begin
        cmd_o.op = svo_pkg::OP_MAG;
        state_d  = svo_pkg::ST_LEVEL;
      end
      svo_pkg::ST_LEVEL: begin
        cmd_o.op = svo_pkg::OP_LEVEL;
        state_d  = svo_pkg::ST_RECIP;
      end
      svo_pkg::ST_RECIP: begin
        cmd_o.op = svo_pkg::OP_RECIP;
        state_d  = svo_pkg::ST_OUT;
      end
      svo_pkg::ST_OUT: begin
        // hold the last step until the result register can take a new sample
        if (status_i.out_free) begin
          cmd_o.op = svo_pkg::OP_OUT;
          state_d  = svo_pkg::ST_IDLE;
        end
      end
      default: state_d = svo_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_out_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == svo_pkg::OP_OUT |-> status_i.out_free)
    else $error("result loaded while output register is blocked");

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == svo_pkg::FUNC_TICK && status_i.sounding
    |=> state_q == svo_pkg::ST_ROM)
    else $error("tick on sounding voice did not start a sample");
`endif

endmodule

### rtl/svo_datapath.sv
// voice state, phase accumulator, wave tables, shared multiplier and result register
// depends on svo_pkg; driven by svo_ctrl commands

module svo_datapath #(
  parameter int unsigned SAMPLE_RATE      = svo_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned PHASE_BITS       = svo_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = svo_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svo_pkg::svo_cmd_t                   cmd_i,
  output svo_pkg::svo_status_t                status_o,
  input  logic                                cfg_valid_i,
  input  logic [1:0]                          cfg_data_i,
  input  logic [svo_pkg::LEVEL_W-1:0]         note_number_i,
  input  logic [svo_pkg::LEVEL_W-1:0]         note_velocity_i,
  input  logic [svo_pkg::ENV_W-1:0]           envelope_gain_i,
  input  logic                                envelope_active_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [svo_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                voice_ended_o
);

  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PQ_W   = PHASE_BITS - 2;
  localparam int unsigned IDXP_W = PQ_W + IDX_W;

  typedef logic [svo_pkg::MAG_W-1:0] sine_rom_t [SINE_TABLE_DEPTH + 1];
  typedef logic [PHASE_BITS-1:0] step_rom_t [svo_pkg::NOTE_COUNT];

  // quarter sine in Q15 from an 11th-order series in Q30
  function automatic sine_rom_t build_sine();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    int                 i;
    int                 k;
    for (i = 0; i <= int'(SINE_TABLE_DEPTH); i++) begin
      x   = (64'(i) * 64'(svo_pkg::HALF_PI_Q30)) / 64'(SINE_TABLE_DEPTH);
      x2  = (x * x) >> 30;
      mag = x;
      sum = $signed(x);
      for (k = 1; k <= 5; k++) begin
        mag = ((mag * x2) >> 30) / 64'(svo_pkg::TAYLOR_DIV[k-1]);
        if ((k & 1) == 1) begin
          sum = sum - $signed(mag);
        end else begin
          sum = sum + $signed(mag);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      rom[i] = svo_pkg::MAG_W'((64'(sum) + 64'd16384) >> 15);
    end
    return rom;
  endfunction

  // phase step per note, rounded, wrapped to the accumulator width
  function automatic step_rom_t build_steps();
    step_rom_t    rom;
    logic [127:0] num;
    logic [127:0] a;
    int           n;
    int           m;
    int           q;
    int           k;
    int           e;
    for (n = 0; n < int'(svo_pkg::NOTE_COUNT); n++) begin
      m   = n + 3;
      q   = m / 12;
      k   = m % 12;
      e   = int'(PHASE_BITS) + q - 36;
      num = 128'(440) * 128'(svo_pkg::SEMITONE_Q30[k]);
      if (e >= 0) begin
        a = ((num << e) + 128'(SAMPLE_RATE / 2)) / 128'(SAMPLE_RATE);
      end else begin
        a = ((num + (128'(SAMPLE_RATE) << (-e - 1))) >> (-e)) / 128'(SAMPLE_RATE);
      end
      rom[n] = a[PHASE_BITS-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM      = build_sine();
  localparam step_rom_t NOTE_STEP_ROM = build_steps();

  // voice state
  logic [PHASE_BITS-1:0]       phase_acc_q, phase_acc_d;
  logic [PHASE_BITS-1:0]       phase_step_q, phase_step_d;
  logic [svo_pkg::LEVEL_W-1:0] level_q, level_d;
  logic                        sounding_q, sounding_d;
  logic [1:0]                  shape_q;
  logic                        out_valid_q, out_valid_d;

  // per-sample working registers
  logic [svo_pkg::FRAC_W-1:0]   f_q;
  logic [1:0]                   quad_q;
  logic [IDX_W-1:0]             idx_q;
  logic [svo_pkg::MAG_W-1:0]    rom_q;
  logic [svo_pkg::ENV_W-1:0]    env_q;
  logic                         ended_q;
  logic                         neg_q;
  logic [svo_pkg::MUL_P_W-1:0]  mul_q;
  logic [svo_pkg::T_W-1:0]      t_q;
  logic signed [svo_pkg::SAMPLE_W-1:0] sample_q;
  logic                         voice_ended_q;

  logic [PQ_W-1:0]               pq;
  logic [IDXP_W-1:0]             idx_prod;
  logic [IDX_W-1:0]              idx_d;
  logic [IDX_W-1:0]              rom_addr;
  logic signed [svo_pkg::RAW_W-1:0] raw;
  logic [svo_pkg::MAG_W-1:0]     mag;
  logic [8:0]                    level3;
  logic [svo_pkg::P_W:0]         p_round;
  logic [svo_pkg::T_W-1:0]       t_d;
  logic [svo_pkg::Q_W-1:0]       q_est;
  logic [svo_pkg::T_W-1:0]       rem;
  logic [svo_pkg::SAMPLE_W-1:0]  r;
  logic signed [svo_pkg::SAMPLE_W-1:0] sample_d;
  logic [svo_pkg::MUL_A_W-1:0]   mul_a;
  logic [svo_pkg::MUL_B_W-1:0]   mul_b;
  logic [svo_pkg::MUL_P_W-1:0]   mul_p;

  // table index for the quarter wave
  assign pq       = phase_acc_q[PQ_W-1:0];
  assign idx_prod = IDXP_W'(pq) * IDXP_W'(SINE_TABLE_DEPTH);
  assign idx_d    = idx_prod[IDXP_W-1 -: IDX_W];
  assign rom_addr = quad_q[0] ? (IDX_W'(SINE_TABLE_DEPTH) - idx_q) : idx_q;

  always_comb begin
    sounding_d   = sounding_q;
    phase_step_d = phase_step_q;
    phase_acc_d  = phase_acc_q;
    level_d      = level_q;
    if (cmd_i.note_start) begin
      level_d      = note_velocity_i;
      phase_acc_d  = '0;
      phase_step_d = NOTE_STEP_ROM[note_number_i];
      sounding_d   = 1'b1;
    end
    if (cmd_i.hard_stop) begin
      sounding_d   = 1'b0;
      phase_step_d = '0;
    end
    if (cmd_i.tick) begin
      phase_acc_d = phase_acc_q + phase_step_q;
      if (!envelope_active_i) begin
        sounding_d   = 1'b0;
        phase_step_d = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.op == svo_pkg::OP_OUT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q  <= '0;
      phase_step_q <= '0;
      level_q      <= '0;
      sounding_q   <= 1'b0;
      shape_q      <= svo_pkg::SHAPE_SINE;
      out_valid_q  <= 1'b0;
    end else begin
      phase_acc_q  <= phase_acc_d;
      phase_step_q <= phase_step_d;
      level_q      <= level_d;
      sounding_q   <= sounding_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        shape_q <= cfg_data_i;
      end
    end
  end

  // raw wave in Q15, -32768..32768
  always_comb begin
    case (shape_q)
      svo_pkg::SHAPE_SINE: begin
        raw = quad_q[1] ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
      end
      svo_pkg::SHAPE_SAW: begin
        raw = 18'sd32768 - $signed({2'b00, f_q});
      end
      svo_pkg::SHAPE_SQUARE: begin
        raw = f_q[15] ? -18'sd32768 : 18'sd32768;
      end
      svo_pkg::SHAPE_TRIANGLE: begin
        if (f_q[15:14] == 2'b00) begin
          raw = $signed({1'b0, f_q, 1'b0});
        end else if (f_q < 16'd49152) begin
          raw = 18'sd65536 - $signed({1'b0, f_q, 1'b0});
        end else begin
          // 2f - 2^17 wraps to setting the top bit
          raw = $signed({1'b1, f_q, 1'b0});
        end
      end
      default: raw = '0;
    endcase
  end

  assign mag     = raw[svo_pkg::RAW_W-1] ? svo_pkg::MAG_W'(-raw) : svo_pkg::MAG_W'(raw);
  assign level3  = {2'b00, level_q} + {1'b0, level_q, 1'b0};
  assign p_round = {1'b0, mul_q[svo_pkg::P_W-1:0]} + {1'b0, svo_pkg::SCALE_HALF};
  assign t_d     = p_round[svo_pkg::SCALE_SHIFT +: svo_pkg::T_W];
  assign q_est   = mul_q[svo_pkg::RECIP_SHIFT +: svo_pkg::Q_W];

  // one shared multiplier, operands picked by the current step
  always_comb begin
    case (cmd_i.op)
      svo_pkg::OP_MAG: begin
        mul_a = svo_pkg::MUL_A_W'(mag);
        mul_b = svo_pkg::MUL_B_W'(env_q);
      end
      svo_pkg::OP_LEVEL: begin
        mul_a = mul_q[svo_pkg::MUL_A_W-1:0];
        mul_b = svo_pkg::MUL_B_W'(level3);
      end
      svo_pkg::OP_RECIP: begin
        mul_a = svo_pkg::MUL_A_W'(t_d);
        mul_b = svo_pkg::SCALE_RECIP;
      end
      svo_pkg::OP_OUT: begin
        mul_a = svo_pkg::MUL_A_W'(q_est);
        mul_b = svo_pkg::MUL_B_W'(svo_pkg::SCALE_DIV);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = svo_pkg::MUL_P_W'(mul_a) * svo_pkg::MUL_P_W'(mul_b);

  // reciprocal estimate is low by at most one
  assign rem = t_q - mul_p[svo_pkg::T_W-1:0];
  assign r   = (rem >= svo_pkg::T_W'(svo_pkg::SCALE_DIV)) ?
               ({1'b0, q_est} + 16'd1) : {1'b0, q_est};

  always_comb begin
    if (neg_q) begin
      if (r > svo_pkg::SAT_NEG_MAG) begin
        sample_d = $signed(svo_pkg::SAT_NEG);
      end else begin
        sample_d = $signed(~r + 16'd1);
      end
    end else begin
      if (r > svo_pkg::SAT_POS) begin
        sample_d = $signed(svo_pkg::SAT_POS);
      end else begin
        sample_d = $signed(r);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      f_q     <= phase_acc_q[PHASE_BITS-1 -: svo_pkg::FRAC_W];
      quad_q  <= phase_acc_q[PHASE_BITS-1 -: 2];
      idx_q   <= idx_d;
      env_q   <= envelope_gain_i;
      ended_q <= !envelope_active_i;
    end
    case (cmd_i.op)
      svo_pkg::OP_ROM: rom_q <= SINE_ROM[rom_addr];
      svo_pkg::OP_MAG: begin
        neg_q <= raw[svo_pkg::RAW_W-1];
        mul_q <= mul_p;
      end
      svo_pkg::OP_LEVEL: mul_q <= mul_p;
      svo_pkg::OP_RECIP: begin
        t_q   <= t_d;
        mul_q <= mul_p;
      end
      svo_pkg::OP_OUT: begin
        sample_q      <= sample_d;
        voice_ended_q <= ended_q;
      end
      default: ;
    endcase
  end

  assign status_o.sounding = sounding_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = sample_q;
  assign voice_ended_o     = voice_ended_q;

`ifndef SYNTH
  a_hard_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hard_stop |=> !sounding_q && (phase_step_q == '0))
    else $error("hard stop left the voice sounding");

  a_env_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick && !envelope_active_i |=> !sounding_q && (phase_step_q == '0))
    else $error("inactive envelope did not end the voice");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == svo_pkg::OP_OUT |=> out_valid_q)
    else $error("finished sample not presented");
`endif

endmodule

### rtl/synth_voice_oscillator_unit.sv
// note start/stop requests do not stall the unit; a sample tick on a sounding voice occupies the
// unit for its table index, sine table read and four passes through the shared multiplier; the last
// pass waits while the result register is blocked, then loads the sample there. ticks on a silent
// voice do not stall the unit. the result register lets the next request in while a sample waits.
// reset (async, active low) clears voice state, wave shape and output valid; tables are
// constants, so no clearing pass is needed
//
// top level of the synth voice oscillator: sequencer plus datapath
// depends on svo_pkg, svo_ctrl, svo_datapath

module synth_voice_oscillator_unit #(
  parameter int unsigned SAMPLE_RATE      = svo_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned PHASE_BITS       = svo_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = svo_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          func_i,
  input  logic [svo_pkg::LEVEL_W-1:0]         note_number_i,
  input  logic [svo_pkg::LEVEL_W-1:0]         note_velocity_i,
  input  logic                                tail_off_i,
  input  logic [svo_pkg::ENV_W-1:0]           envelope_gain_i,
  input  logic                                envelope_active_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [svo_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                voice_ended_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_data_i
);

  svo_pkg::svo_cmd_t    cmd;
  svo_pkg::svo_status_t status;

  // shape register can always be written
  assign cfg_ready_o = 1'b1;

  svo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .tail_off_i (tail_off_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  svo_datapath #(
    .SAMPLE_RATE      (SAMPLE_RATE),
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .note_number_i     (note_number_i),
    .note_velocity_i   (note_velocity_i),
    .envelope_gain_i   (envelope_gain_i),
    .envelope_active_i (envelope_active_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .sample_out_o      (sample_out_o),
    .voice_ended_o     (voice_ended_o)
  );

endmodule
